FILE: design/countdown_timer_with_alert_assert.svh
// Assertion macros used by the countdown timer core (cdt_core).
`ifndef COUNTDOWN_TIMER_WITH_ALERT_ASSERT_SVH
`define COUNTDOWN_TIMER_WITH_ALERT_ASSERT_SVH

// Property that must hold at every clock edge outside reset.
`define CDT_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Condition in one cycle that implies a consequence in the next cycle.
`define CDT_ASSERT_NEXT(label, cond, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (cons)) \
		else $error(msg);

`endif

FILE: design/cdt_pkg.sv
// Types, constants and helper functions of the countdown timer.
package cdt_pkg;

	// Bar geometry.
	localparam int BAR_LEDS = 5;
	localparam int BAR_CAP = (BAR_LEDS > 7) ? 7 : BAR_LEDS;
	localparam logic [4:0] BAR_MASK = 5'(((1 << BAR_CAP) - 1) & 31);
	localparam logic [4:0] BAR_ALT = 5'(32'h5555_5555 & ((1 << BAR_CAP) - 1) & 31);
	localparam logic [2:0] PRESS_CAP = 3'(BAR_CAP);

	// Field widths.
	localparam int SEC_W = 15;
	localparam int TICK_W = 10;
	localparam int STEP_W = 6;
	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W = 10;
	localparam logic [SEC_W-1:0] SEC_MAX = 15'h7FFF;

	// Commands carried in tuser.
	localparam logic [1:0] CMD_TICK = 2'd0;
	localparam logic [1:0] CMD_START = 2'd1;
	localparam logic [1:0] CMD_RESET = 2'd2;

	// Operating modes.
	localparam logic [1:0] MODE_IDLE = 2'd0;
	localparam logic [1:0] MODE_COUNT = 2'd1;
	localparam logic [1:0] MODE_ALERT = 2'd2;

	// Alert phases: red, green, blue, then motor.
	localparam logic [2:0] PH_RED = 3'd0;
	localparam logic [2:0] PH_BLUE = 3'd2;
	localparam logic [2:0] PH_MOTOR = 3'd3;

	// Configuration register indexes.
	localparam logic [CFG_INDEX_W-1:0] REG_TICKS_PER_SECOND = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_BLINK_STEP_TICKS = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_COLOR_STEP_TICKS = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_MOTOR_PULSE_TICKS = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_BLINK_STEP_COUNT = 3'd4;
	localparam logic [CFG_INDEX_W-1:0] REG_ALERT_CYCLE_COUNT = 3'd5;

	// Input item.
	typedef struct packed {
		logic [1:0] cmd;
		logic       sel_10;
		logic       sel_20;
		logic       sel_30;
		logic       sel_60;
		logic       color_alert_en;
		logic       shake_alert_en;
	} item_t;

	// Configuration registers.
	typedef struct packed {
		logic [TICK_W-1:0] ticks_per_second;
		logic [TICK_W-1:0] blink_step_ticks;
		logic [TICK_W-1:0] color_step_ticks;
		logic [TICK_W-1:0] motor_pulse_ticks;
		logic [STEP_W-1:0] blink_step_count;
		logic [STEP_W-1:0] alert_cycle_count;
	} cfg_t;

	// Result item.
	typedef struct packed {
		logic [4:0]       bar_leds;
		logic [2:0]       rgb_leds;
		logic             motor_drive;
		logic [1:0]       mode;
		logic [SEC_W-1:0] remaining_seconds;
		logic [2:0]       bar_count;
	} result_t;

	// A tick count of zero behaves as one.
	function automatic logic [TICK_W-1:0] min_one_ticks(input logic [TICK_W-1:0] v);
		return (v == '0) ? TICK_W'(1) : v;
	endfunction

	// A step count of zero behaves as one.
	function automatic logic [STEP_W-1:0] min_one_steps(input logic [STEP_W-1:0] v);
		return (v == '0) ? STEP_W'(1) : v;
	endfunction

	// Bar with the lowest n LEDs lit.
	function automatic logic [4:0] bar_fill(input logic [2:0] n);
		logic [7:0] full;
		full = (8'd1 << n) - 8'd1;
		return full[4:0] & BAR_MASK;
	endfunction

endpackage

FILE: design/countdown_timer_with_alert.sv
// A transfer in is registered in the input register, then its result in the output register.
// Throughput: one item per cycle unless the output register is full and m_tready is low.
// Each register holds one item; input keeps taking items while the output register drains.
// Reset (arst_n low) empties both registers, clears the timer state and the alert state at
// once, and loads the configuration registers with their defaults.
module countdown_timer_with_alert
	import cdt_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	// s_tdata: sel_10, sel_20, sel_30, sel_60, color_alert_en, shake_alert_en, two unused bits
	input  logic [7:0]             s_tdata,
	// s_tuser: cmd
	input  logic [1:0]             s_tuser,
	output logic                   m_tvalid,
	input  logic                   m_tready,
	// m_tdata: bar_leds[4:0], rgb_leds[7:5], motor_drive[8], mode[10:9],
	// remaining_seconds[25:11], bar_count[28:26], three zero bits
	output logic [31:0]            m_tdata,
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

	logic    valid_s1;
	item_t   item_s1;
	logic    out_valid_q;
	result_t res_q;
	result_t res_next;
	cfg_t    cfg_q;
	logic    advance;

	assign advance = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.ticks_per_second <= TICK_W'(20);
			cfg_q.blink_step_ticks <= TICK_W'(5);
			cfg_q.color_step_ticks <= TICK_W'(4);
			cfg_q.motor_pulse_ticks <= TICK_W'(8);
			cfg_q.blink_step_count <= STEP_W'(40);
			cfg_q.alert_cycle_count <= STEP_W'(10);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_TICKS_PER_SECOND: cfg_q.ticks_per_second <= cfg_wdata;
				REG_BLINK_STEP_TICKS: cfg_q.blink_step_ticks <= cfg_wdata;
				REG_COLOR_STEP_TICKS: cfg_q.color_step_ticks <= cfg_wdata;
				REG_MOTOR_PULSE_TICKS: cfg_q.motor_pulse_ticks <= cfg_wdata;
				REG_BLINK_STEP_COUNT: cfg_q.blink_step_count <= cfg_wdata[STEP_W-1:0];
				REG_ALERT_CYCLE_COUNT: cfg_q.alert_cycle_count <= cfg_wdata[STEP_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Input register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	// Input register payload.
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			item_s1 <= '{
				cmd: s_tuser,
				sel_10: s_tdata[0],
				sel_20: s_tdata[1],
				sel_30: s_tdata[2],
				sel_60: s_tdata[3],
				color_alert_en: s_tdata[4],
				shake_alert_en: s_tdata[5]
			};
		end
	end

	cdt_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.step_en (advance),
		.item    (item_s1),
		.cfg     (cfg_q),
		.res_next(res_next)
	);

	// Output register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res_next;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata = {3'b000, res_q.bar_count, res_q.remaining_seconds, res_q.mode,
		res_q.motor_drive, res_q.rgb_leds, res_q.bar_leds};

endmodule

FILE: design/cdt_core.sv
// Timer state registers and the next-state logic for one item.
`include "countdown_timer_with_alert_assert.svh"

module cdt_core
	import cdt_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    step_en,
	input  item_t   item,
	input  cfg_t    cfg,
	output result_t res_next
);

	logic [1:0]        mode_q, mode_d;
	logic [SEC_W-1:0]  sec_q, sec_d;
	logic [2:0]        press_q, press_d;
	logic [TICK_W-1:0] sub_q, sub_d;
	logic [STEP_W-1:0] steps_q, steps_d;
	logic [TICK_W-1:0] phase_q, phase_d;
	logic [2:0]        aphase_q, aphase_d;
	logic [1:0]        kind_q, kind_d;
	logic [4:0]        bar_q, bar_d;
	logic [2:0]        rgb_q, rgb_d;
	logic              motor_q, motor_d;

	logic [7:0]        inc;
	logic [SEC_W:0]    sec_sum;
	logic              end_cycle;
	logic              start_cycle;

	// Next state for the item now leaving the input register.
	always_comb begin
		mode_d = mode_q;
		sec_d = sec_q;
		press_d = press_q;
		sub_d = sub_q;
		steps_d = steps_q;
		phase_d = phase_q;
		aphase_d = aphase_q;
		kind_d = kind_q;
		bar_d = bar_q;
		rgb_d = rgb_q;
		motor_d = motor_q;
		end_cycle = 1'b0;
		start_cycle = 1'b0;
		inc = (item.sel_10 ? 8'd10 : 8'd0) + (item.sel_20 ? 8'd20 : 8'd0)
			+ (item.sel_30 ? 8'd30 : 8'd0) + (item.sel_60 ? 8'd60 : 8'd0);
		if (inc == 8'd0) begin
			inc = 8'd1;
		end
		sec_sum = {1'b0, sec_q} + {8'd0, inc};

		case (item.cmd)
			CMD_RESET: begin
				mode_d = MODE_IDLE;
				sec_d = '0;
				press_d = '0;
				sub_d = '0;
				steps_d = '0;
				phase_d = '0;
				aphase_d = '0;
				kind_d = '0;
				bar_d = '0;
				rgb_d = '0;
				motor_d = 1'b0;
			end
			CMD_START: begin
				if (mode_q != MODE_COUNT) begin
					sub_d = '0;
				end
				mode_d = MODE_COUNT;
				sec_d = (sec_sum > {1'b0, SEC_MAX}) ? SEC_MAX : sec_sum[SEC_W-1:0];
				if (press_q < PRESS_CAP) begin
					press_d = press_q + 3'd1;
				end
				bar_d = bar_fill(press_d);
				rgb_d = '0;
				motor_d = 1'b0;
				steps_d = '0;
				phase_d = '0;
				aphase_d = '0;
				kind_d = '0;
			end
			CMD_TICK: begin
				if (mode_q == MODE_COUNT) begin
					// One second goes by after the configured number of ticks.
					sub_d = sub_q + TICK_W'(1);
					if (sub_d >= min_one_ticks(cfg.ticks_per_second)) begin
						sub_d = '0;
						if (sec_q != '0) begin
							sec_d = sec_q - SEC_W'(1);
						end
						if (sec_d == '0) begin
							mode_d = MODE_ALERT;
							kind_d = {item.shake_alert_en, item.color_alert_en};
							steps_d = '0;
							phase_d = '0;
							aphase_d = '0;
							if (kind_d == 2'd0) begin
								bar_d = BAR_ALT ^ BAR_MASK;
							end else begin
								start_cycle = 1'b1;
							end
						end
					end
				end else if (mode_q == MODE_ALERT) begin
					phase_d = phase_q + TICK_W'(1);
					if (kind_q == 2'd0) begin
						// Bar blink alert.
						if (phase_d >= min_one_ticks(cfg.blink_step_ticks)) begin
							phase_d = '0;
							steps_d = steps_q + STEP_W'(1);
							if (steps_d >= min_one_steps(cfg.blink_step_count) ||
									steps_d == '0) begin
								bar_d = '0;
								mode_d = MODE_IDLE;
								steps_d = '0;
							end else begin
								bar_d = bar_q ^ BAR_MASK;
							end
						end
					end else if (aphase_q <= PH_BLUE) begin
						// Colour steps.
						if (phase_d >= min_one_ticks(cfg.color_step_ticks)) begin
							phase_d = '0;
							if (aphase_q < PH_BLUE) begin
								aphase_d = aphase_q + 3'd1;
								rgb_d = 3'b001 << aphase_d;
							end else if (kind_q[1]) begin
								aphase_d = PH_MOTOR;
								motor_d = 1'b1;
							end else begin
								end_cycle = 1'b1;
							end
						end
					end else begin
						// Motor pulse.
						if (phase_d >= min_one_ticks(cfg.motor_pulse_ticks)) begin
							motor_d = 1'b0;
							end_cycle = 1'b1;
						end
					end
				end
			end
			default: begin
			end
		endcase

		// End of one alert cycle of colour steps, motor pulse or both.
		if (end_cycle) begin
			steps_d = steps_q + STEP_W'(1);
			if (steps_d >= min_one_steps(cfg.alert_cycle_count) || steps_d == '0) begin
				rgb_d = '0;
				motor_d = 1'b0;
				mode_d = MODE_IDLE;
				steps_d = '0;
				phase_d = '0;
				aphase_d = '0;
			end else begin
				start_cycle = 1'b1;
			end
		end

		// Entry into the first phase of a cycle.
		if (start_cycle) begin
			phase_d = '0;
			if (kind_d[0]) begin
				aphase_d = PH_RED;
				rgb_d = 3'b001;
			end else begin
				aphase_d = PH_MOTOR;
				motor_d = 1'b1;
			end
		end
	end

	// State registers advance once per transfer out of the input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_IDLE;
			sec_q <= '0;
			press_q <= '0;
			sub_q <= '0;
			steps_q <= '0;
			phase_q <= '0;
			aphase_q <= '0;
			kind_q <= '0;
			bar_q <= '0;
			rgb_q <= '0;
			motor_q <= 1'b0;
		end else if (step_en) begin
			mode_q <= mode_d;
			sec_q <= sec_d;
			press_q <= press_d;
			sub_q <= sub_d;
			steps_q <= steps_d;
			phase_q <= phase_d;
			aphase_q <= aphase_d;
			kind_q <= kind_d;
			bar_q <= bar_d;
			rgb_q <= rgb_d;
			motor_q <= motor_d;
		end
	end

	// The result shows the state after the item.
	assign res_next = '{
		bar_leds: bar_d,
		rgb_leds: rgb_d,
		motor_drive: motor_d,
		mode: mode_d,
		remaining_seconds: sec_d,
		bar_count: press_d
	};

	`CDT_ASSERT(a_rgb_single, $onehot0(rgb_q), "more than one colour lit")
	`CDT_ASSERT(a_motor_alert, !motor_q || mode_q == MODE_ALERT, "motor on outside alert")
	`CDT_ASSERT(a_count_nonzero, mode_q != MODE_COUNT || sec_q != '0, "counting with zero left")
	`CDT_ASSERT(a_press_cap, press_q <= PRESS_CAP, "press count beyond bar")
	`CDT_ASSERT_NEXT(a_reset_press, step_en && item.cmd == CMD_RESET,
		mode_q == MODE_IDLE && sec_q == '0 && press_q == '0 && bar_q == '0,
		"reset press did not clear state")

endmodule
